### rtl/tksi_pkg.sv
// Shared types and constants of the top-k sorted insert core.
// No dependencies; every other file of the block but tksi_ram imports this package.
package tksi_pkg;

    // Slot memory geometry
    localparam int LIST_DEPTH = 16;
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    // Field widths
    localparam int FUNC_W  = 2;
    localparam int ID_W    = 32;
    localparam int VALUE_W = 48;
    localparam int CPU_W   = 24;
    localparam int RATE_W  = 40;
    localparam int RANK_W  = 4;
    localparam int MODE_W  = 2;
    localparam int LIMIT_W = 5;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_SORT_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_LIMIT = 1'd1;

    localparam logic [MODE_W-1:0]  SORT_MODE_RESET  = 2'd0;
    localparam logic [LIMIT_W-1:0] KEEP_LIMIT_RESET = 5'd16;

    // Operations
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_OFFER = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DUMP  = 2'd2;

    // Ranking keys; any other code ranks by memory
    localparam logic [MODE_W-1:0] MODE_MEM  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CPU  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DISK = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [ID_W-1:0]    pid;
        logic [VALUE_W-1:0] mem_bytes;
        logic [CPU_W-1:0]   cpu_milli;
        logic               cpu_known;
        logic [RATE_W-1:0]  read_rate;
        logic               read_known;
        logic [RATE_W-1:0]  write_rate;
        logic               write_known;
    } in_word_t;

    typedef struct packed {
        logic [ID_W-1:0]    entry_id;
        logic [VALUE_W-1:0] entry_value;
        logic [RANK_W-1:0]  rank;
        logic               list_empty;
        logic               last;
    } out_word_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [VALUE_W-1:0] value;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef struct packed {
        logic               ok;
        logic [VALUE_W-1:0] value;
    } key_t;

    // Slot memory access from the sequencer
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        slot_t            wdata;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

endpackage

### rtl/tksi_if.sv
// Valid/ready channels of the top-k sorted insert core: input and result words.
// Depends on tksi_pkg for the payload types.
interface tksi_in_if;
    import tksi_pkg::*;

    logic     valid;
    logic     ready;
    in_word_t word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

interface tksi_out_if;
    import tksi_pkg::*;

    logic      valid;
    logic      ready;
    out_word_t word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

### rtl/tksi_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tksi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/tksi_key.sv
// Ranking key and eligibility of an offered record for the selected sort mode.
// Depends on tksi_pkg.
module tksi_key (
    input  tksi_pkg::in_word_t            word,
    input  logic [tksi_pkg::MODE_W-1:0]   sort_mode,
    output tksi_pkg::key_t                key
);
    import tksi_pkg::*;

    logic [RATE_W-1:0] rd_rate;
    logic [RATE_W-1:0] wr_rate;
    logic [RATE_W:0]   disk_sum;

    always_comb
    begin
        rd_rate  = word.read_known  ? word.read_rate  : '0;
        wr_rate  = word.write_known ? word.write_rate : '0;
        disk_sum = (RATE_W+1)'(rd_rate) + (RATE_W+1)'(wr_rate);

        case (sort_mode)
            MODE_CPU:
            begin
                key.ok    = word.cpu_known;
                key.value = word.cpu_known ? VALUE_W'(word.cpu_milli) : '0;
            end
            MODE_DISK:
            begin
                key.ok    = (disk_sum != '0);
                key.value = VALUE_W'(disk_sum);
            end
            default:
            begin
                key.ok    = (word.mem_bytes != '0);
                key.value = word.mem_bytes;
            end
        endcase
    end

endmodule

### rtl/tksi_ctrl.sv
// Sequencer of the top-k core: insertion walk over the slot memory, list dump,
// fill count and the result register. Depends on tksi_pkg and tksi_if.
module tksi_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    tksi_in_if.sink                        item,
    tksi_out_if.source                     result,
    input  tksi_pkg::key_t                 key,
    input  logic [tksi_pkg::LIMIT_W-1:0]   keep_limit,
    output tksi_pkg::ram_req_t             ram,
    input  tksi_pkg::slot_t                rdata
);
    import tksi_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_PLACE = 3'd3;
    localparam logic [2:0] ST_DRD   = 3'd4;
    localparam logic [2:0] ST_DLD   = 3'd5;

    logic [2:0]         state_reg,     state_next;
    logic [CNT_W-1:0]   fill_reg,      fill_next;
    logic [IDX_W-1:0]   hole_reg,      hole_next;
    logic [IDX_W-1:0]   didx_reg,      didx_next;
    logic [VALUE_W-1:0] key_reg,       key_next;
    logic [ID_W-1:0]    id_reg,        id_next;
    logic               out_valid_reg, out_valid_next;
    out_word_t          out_word_reg,  out_word_next;

    logic [CNT_W-1:0]   lim;
    logic               out_free;
    logic               dump_last;
    slot_t              new_slot;

    assign item.ready   = (state_reg == ST_IDLE);
    assign result.valid = out_valid_reg;
    assign result.word  = out_word_reg;

    assign out_free  = !out_valid_reg || result.ready;
    assign dump_last = (CNT_W'(CNT_W'(didx_reg) + 1'b1) == fill_reg);

    always_comb
    begin
        if (8'(keep_limit) > 8'(LIST_DEPTH))
        begin
            lim = CNT_W'(LIST_DEPTH);
        end
        else
        begin
            lim = CNT_W'(keep_limit);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        hole_next      = hole_reg;
        didx_next      = didx_reg;
        key_next       = key_reg;
        id_next        = id_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_word_next  = out_word_reg;

        new_slot.id    = id_reg;
        new_slot.value = key_reg;

        ram.we    = 1'b0;
        ram.waddr = '0;
        ram.wdata = new_slot;
        ram.raddr = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    case (item.word.func)
                        FUNC_CLEAR:
                        begin
                            fill_next = '0;
                        end
                        FUNC_OFFER:
                        begin
                            key_next = key.value;
                            id_next  = item.word.pid;
                            if (key.ok && lim != '0)
                            begin
                                if (fill_reg >= lim)
                                begin
                                    // full: must beat the last entry first
                                    ram.raddr  = IDX_W'(fill_reg - 1'b1);
                                    state_next = ST_CHECK;
                                end
                                else
                                begin
                                    fill_next = CNT_W'(fill_reg + 1'b1);
                                    if (fill_reg == '0)
                                    begin
                                        ram.we          = 1'b1;
                                        ram.waddr       = '0;
                                        ram.wdata.id    = item.word.pid;
                                        ram.wdata.value = key.value;
                                    end
                                    else
                                    begin
                                        hole_next  = IDX_W'(fill_reg);
                                        ram.raddr  = IDX_W'(fill_reg - 1'b1);
                                        state_next = ST_SCAN;
                                    end
                                end
                            end
                        end
                        FUNC_DUMP:
                        begin
                            didx_next  = '0;
                            state_next = ST_DRD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                if (rdata.value < key_reg)
                begin
                    // last entry is dropped; its slot becomes the hole
                    hole_next = IDX_W'(fill_reg - 1'b1);
                    if (fill_reg == CNT_W'(1))
                    begin
                        ram.we     = 1'b1;
                        ram.waddr  = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ram.raddr  = IDX_W'(fill_reg - CNT_W'(2));
                        state_next = ST_SCAN;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                // rdata holds the entry just above the hole
                if (rdata.value < key_reg)
                begin
                    ram.we    = 1'b1;
                    ram.waddr = hole_reg;
                    ram.wdata = rdata;
                    hole_next = IDX_W'(hole_reg - 1'b1);
                    if (hole_reg == IDX_W'(1))
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        ram.raddr = IDX_W'(hole_reg - IDX_W'(2));
                    end
                end
                else
                begin
                    ram.we     = 1'b1;
                    ram.waddr  = hole_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_PLACE:
            begin
                ram.we     = 1'b1;
                ram.waddr  = hole_reg;
                state_next = ST_IDLE;
            end
            ST_DRD:
            begin
                if (out_free)
                begin
                    if (fill_reg == '0)
                    begin
                        out_valid_next            = 1'b1;
                        out_word_next.entry_id    = '0;
                        out_word_next.entry_value = '0;
                        out_word_next.rank        = '0;
                        out_word_next.list_empty  = 1'b1;
                        out_word_next.last        = 1'b1;
                        state_next                = ST_IDLE;
                    end
                    else
                    begin
                        ram.raddr  = didx_reg;
                        state_next = ST_DLD;
                    end
                end
            end
            ST_DLD:
            begin
                out_valid_next            = 1'b1;
                out_word_next.entry_id    = rdata.id;
                out_word_next.entry_value = rdata.value;
                out_word_next.rank        = RANK_W'(didx_reg);
                out_word_next.list_empty  = 1'b0;
                out_word_next.last        = dump_last;
                if (dump_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    didx_next  = IDX_W'(didx_reg + 1'b1);
                    state_next = ST_DRD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            hole_reg      <= '0;
            didx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            hole_reg      <= hole_next;
            didx_reg      <= didx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        id_reg       <= id_next;
        out_word_reg <= out_word_next;
    end

endmodule

### rtl/top_k_sorted_insert_core.sv
// Top level of the top-k sorted insert core: configuration registers, key unit,
// sequencer and slot memory. Depends on tksi_pkg, tksi_if, tksi_ram, tksi_key, tksi_ctrl.
//
// Keeps a descending list of up to keep_limit records (at most LIST_DEPTH) in one
// slot memory with a registered read. An offer walks up from the bottom
// of the list, one entry per cycle through the memory's single read port, moving
// smaller entries down one place. An offer that is not eligible is dropped, and one
// into an empty list is written straight to slot 0; in a full list it is first
// compared with the last entry and dropped unless it beats it, else the walk follows.
// A dump gives one result word per entry, each read from memory and then loaded
// into the result register, and a single list_empty word when the list holds
// nothing. The result register lets the next word in while the last dump word
// is still waiting. There is no clearing pass after reset. Write sort_mode and
// keep_limit only while the core is idle.
module top_k_sorted_insert_core (
    input  logic                               clk,
    input  logic                               rst_n,
    tksi_in_if.sink                            item,
    tksi_out_if.source                         result,
    input  logic                               cfg_we,
    input  logic [tksi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tksi_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tksi_pkg::*;

    logic [MODE_W-1:0]  sort_mode_reg,  sort_mode_next;
    logic [LIMIT_W-1:0] keep_limit_reg, keep_limit_next;

    key_t               key;
    ram_req_t           ram_req;
    slot_t              ram_slot;
    logic [SLOT_W-1:0]  ram_rdata;

    always_comb
    begin
        sort_mode_next  = sort_mode_reg;
        keep_limit_next = keep_limit_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SORT_MODE:  sort_mode_next  = MODE_W'(cfg_data);
                CFG_KEEP_LIMIT: keep_limit_next = LIMIT_W'(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sort_mode_reg  <= SORT_MODE_RESET;
            keep_limit_reg <= KEEP_LIMIT_RESET;
        end
        else
        begin
            sort_mode_reg  <= sort_mode_next;
            keep_limit_reg <= keep_limit_next;
        end
    end

    tksi_key u_key (
        .word      (item.word),
        .sort_mode (sort_mode_reg),
        .key       (key)
    );

    tksi_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .result     (result),
        .key        (key),
        .keep_limit (keep_limit_reg),
        .ram        (ram_req),
        .rdata      (ram_slot)
    );

    assign ram_slot = ram_rdata;

    tksi_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (LIST_DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

endmodule

### tb/tb_top_k_sorted_insert_core.sv
// Self-checking testbench for top_k_sorted_insert_core: directed and random words
// against a behavioral copy of the ranked list, under varying idle and stall pressure.
// Depends on tksi_pkg, tksi_if and the core RTL.
`timescale 1ns / 100ps

module tb_top_k_sorted_insert_core;
    import tksi_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;   // unused opcode, ignored by core
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;   // ranks like memory
    localparam int SETTLE_CYCLES = 24;                  // longest offer walk plus margin
    localparam int MAX_PRINTED   = 30;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tksi_in_if  item_bus ();
    tksi_out_if result_bus ();

    top_k_sorted_insert_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_bus),
        .result    (result_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow of the ranked list and its configuration
    logic [ID_W-1:0]    top_id  [LIST_DEPTH];
    logic [VALUE_W-1:0] top_val [LIST_DEPTH];
    int                 top_fill;
    logic [MODE_W-1:0]  cur_mode;
    int                 cur_limit;

    in_word_t  word_backlog[$];
    out_word_t expected_entries[$];
    int        words_queued;
    int        words_taken;
    int        fail_count;
    int        send_idle_pct;
    int        recv_stall_pct;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    task automatic log_mismatch(input string what);
        fail_count++;
        if (fail_count <= MAX_PRINTED)
            $display("%0t ERROR %s", $time, what);
    endtask

    // Applies one accepted word to the shadow list; a dump queues the words it yields
    function automatic void track_list(input in_word_t w);
        logic [VALUE_W-1:0] k;
        logic [VALUE_W-1:0] tv;
        logic [ID_W-1:0]    ti;
        logic               ok;
        int                 lim;
        int                 n;
        int                 pos;
        out_word_t          r;
        case (w.func)
            FUNC_CLEAR: top_fill = 0;
            FUNC_OFFER:
            begin
                if (cur_mode == MODE_CPU)
                begin
                    ok = w.cpu_known;
                    k  = ok ? {{(VALUE_W-CPU_W){1'b0}}, w.cpu_milli} : '0;
                end
                else if (cur_mode == MODE_DISK)
                begin
                    k = '0;
                    if (w.read_known)
                        k = k + w.read_rate;
                    if (w.write_known)
                        k = k + w.write_rate;
                    ok = (k != 0);
                end
                else
                begin
                    k  = w.mem_bytes;
                    ok = (k != 0);
                end
                lim = (cur_limit > LIST_DEPTH) ? LIST_DEPTH : cur_limit;
                n   = top_fill;
                pos = -1;
                if (ok && lim != 0)
                begin
                    if (n < lim)
                    begin
                        pos      = n;
                        top_fill = n + 1;
                    end
                    else if (k > top_val[n-1])
                        pos = n - 1;   // list full: newcomer displaces the tail
                end
                if (pos >= 0)
                begin
                    top_id[pos]  = w.pid;
                    top_val[pos] = k;
                    // strict compare keeps older entries above equal keys
                    while (pos > 0 && top_val[pos] > top_val[pos-1])
                    begin
                        ti = top_id[pos];
                        tv = top_val[pos];
                        top_id[pos]    = top_id[pos-1];
                        top_val[pos]   = top_val[pos-1];
                        top_id[pos-1]  = ti;
                        top_val[pos-1] = tv;
                        pos--;
                    end
                end
            end
            FUNC_DUMP:
            begin
                if (top_fill == 0)
                begin
                    r = '0;
                    r.list_empty = 1'b1;
                    r.last       = 1'b1;
                    expected_entries.push_back(r);
                end
                for (int i = 0; i < top_fill; i++)
                begin
                    r.entry_id    = top_id[i];
                    r.entry_value = top_val[i];
                    r.rank        = i[RANK_W-1:0];
                    r.list_empty  = 1'b0;
                    r.last        = (i == top_fill - 1);
                    expected_entries.push_back(r);
                end
            end
            default: ;
        endcase
    endfunction

    // Mix of tiny values (ties), all ones, scaled-down and full-width random
    function automatic logic [63:0] pick_value(input int bits);
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0, 1: v = 64'($urandom_range(0, 9));
            2:    v = '1;
            3:    v = v >> $urandom_range(0, bits - 1);
            default: ;
        endcase
        return v & ((64'd1 << bits) - 64'd1);
    endfunction

    function automatic in_word_t random_word(input logic [FUNC_W-1:0] func);
        in_word_t w;
        w.func        = func;
        w.pid         = $urandom;
        w.mem_bytes   = VALUE_W'(pick_value(VALUE_W));
        w.cpu_milli   = CPU_W'(pick_value(CPU_W));
        w.cpu_known   = ($urandom_range(0, 3) != 0);
        w.read_rate   = RATE_W'(pick_value(RATE_W));
        w.read_known  = ($urandom_range(0, 3) != 0);
        w.write_rate  = RATE_W'(pick_value(RATE_W));
        w.write_known = ($urandom_range(0, 3) != 0);
        return w;
    endfunction

    function automatic in_word_t offer_word(
        input logic [ID_W-1:0]    pid,
        input logic [VALUE_W-1:0] mem,
        input logic [CPU_W-1:0]   cpu,
        input logic               cpu_ok,
        input logic [RATE_W-1:0]  rd,
        input logic               rd_ok,
        input logic [RATE_W-1:0]  wr,
        input logic               wr_ok
    );
        in_word_t w;
        w.func        = FUNC_OFFER;
        w.pid         = pid;
        w.mem_bytes   = mem;
        w.cpu_milli   = cpu;
        w.cpu_known   = cpu_ok;
        w.read_rate   = rd;
        w.read_known  = rd_ok;
        w.write_rate  = wr;
        w.write_known = wr_ok;
        return w;
    endfunction

    task automatic enqueue(input in_word_t w);
        word_backlog.push_back(w);
        words_queued++;
    endtask

    // Wait until every queued word is taken and every dump word has come back
    task automatic settle();
        @(posedge clk);
        while (words_taken != words_queued || expected_entries.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SORT_MODE)
            cur_mode = data[MODE_W-1:0];
        else
            cur_limit = int'(data);
    endtask

    task automatic configure(input logic [MODE_W-1:0] mode, input int limit);
        settle();
        write_reg(CFG_SORT_MODE, CFG_DATA_W'(mode));
        write_reg(CFG_KEEP_LIMIT, CFG_DATA_W'(limit));
    endtask

    task automatic run_phase(input logic [MODE_W-1:0] mode, input int limit,
                             input int send_pct, input int recv_pct, input int count);
        int pick;
        configure(mode, limit);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                enqueue(random_word(FUNC_OFFER));
            else if (pick < 92)
                enqueue(random_word(FUNC_DUMP));
            else if (pick < 96)
                enqueue(random_word(FUNC_CLEAR));
            else
                enqueue(random_word(FUNC_NONE));
        end
        enqueue(random_word(FUNC_DUMP));
    endtask

    // Input driver: holds a word until taken, then maybe idles
    always @(posedge clk)
    begin : drive_items
        logic fire;
        if (rst_n)
        begin
            fire = item_bus.valid && item_bus.ready;
            if (fire)
            begin
                track_list(item_bus.word);
                words_taken++;
            end
            if (!item_bus.valid || fire)
            begin
                if (word_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    item_bus.word  <= word_backlog.pop_front();
                    item_bus.valid <= 1'b1;
                end
                else
                    item_bus.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
            result_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Result monitor
    always @(posedge clk)
    begin : watch_results
        out_word_t want;
        out_word_t got;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            got = result_bus.word;
            if (expected_entries.size() == 0)
                log_mismatch($sformatf("unexpected result word %h", got));
            else
            begin
                want = expected_entries.pop_front();
                if (got.entry_id !== want.entry_id)
                    log_mismatch($sformatf("entry_id %h, want %h",
                                           got.entry_id, want.entry_id));
                if (got.entry_value !== want.entry_value)
                    log_mismatch($sformatf("entry_value %h, want %h",
                                           got.entry_value, want.entry_value));
                if (got.rank !== want.rank)
                    log_mismatch($sformatf("rank %0d, want %0d", got.rank, want.rank));
                if (got.list_empty !== want.list_empty)
                    log_mismatch($sformatf("list_empty %b, want %b",
                                           got.list_empty, want.list_empty));
                if (got.last !== want.last)
                    log_mismatch($sformatf("last %b, want %b", got.last, want.last));
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        item_bus.valid   = 1'b0;
        item_bus.word    = '0;
        result_bus.ready = 1'b0;
        cur_mode         = SORT_MODE_RESET;
        cur_limit        = int'(KEEP_LIMIT_RESET);
        top_fill         = 0;
        words_queued     = 0;
        words_taken      = 0;
        fail_count       = 0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: memory key, full depth
        enqueue(random_word(FUNC_DUMP));   // empty list
        enqueue(random_word(FUNC_NONE));
        enqueue(offer_word(32'h0000_00A0, '0, 24'h1, 1'b1, 40'h5, 1'b1, 40'h5, 1'b1));
        enqueue(offer_word('1, '1, '0, 1'b0, '0, 1'b0, '0, 1'b0));
        enqueue(offer_word('0, 48'd1, '0, 1'b0, '0, 1'b0, '0, 1'b0));
        enqueue(offer_word(32'd11, 48'd5, '1, 1'b1, '1, 1'b1, '1, 1'b1));
        enqueue(offer_word(32'd12, 48'd5, '0, 1'b0, '0, 1'b0, '0, 1'b0));   // tie
        enqueue(random_word(FUNC_DUMP));
        enqueue(random_word(FUNC_CLEAR));
        enqueue(random_word(FUNC_DUMP));

        // cpu key, two entries; zero cpu is still a valid key
        configure(MODE_CPU, 2);
        enqueue(offer_word(32'd20, 48'd9, '1, 1'b0, '0, 1'b0, '0, 1'b0));
        enqueue(offer_word(32'd21, '0, '1, 1'b1, '0, 1'b0, '0, 1'b0));
        enqueue(offer_word(32'd22, '0, '0, 1'b1, '0, 1'b0, '0, 1'b0));
        enqueue(offer_word(32'd23, '0, '0, 1'b1, '0, 1'b0, '0, 1'b0));   // tie at full
        enqueue(random_word(FUNC_DUMP));

        // disk key with entries kept from cpu mode; limit above depth saturates
        configure(MODE_DISK, 31);
        enqueue(offer_word(32'd30, '0, '0, 1'b0, '1, 1'b1, '1, 1'b1));
        enqueue(offer_word(32'd31, '1, '1, 1'b1, '1, 1'b0, '1, 1'b0));
        enqueue(offer_word(32'd32, '0, '0, 1'b0, 40'd3, 1'b1, '1, 1'b0));
        enqueue(offer_word(32'd33, '0, '0, 1'b0, '1, 1'b0, 40'd3, 1'b1));
        enqueue(random_word(FUNC_DUMP));

        // limit below fill: tail entry is up for replacement
        configure(MODE_UNUSED, 1);
        enqueue(offer_word(32'd40, 48'd2, '0, 1'b0, '0, 1'b0, '0, 1'b0));
        enqueue(offer_word(32'd41, '0, '1, 1'b1, '1, 1'b1, '1, 1'b1));
        enqueue(random_word(FUNC_DUMP));

        configure(MODE_MEM, 0);
        enqueue(offer_word(32'd50, '1, '0, 1'b0, '0, 1'b0, '0, 1'b0));
        enqueue(random_word(FUNC_DUMP));

        run_phase(MODE_MEM,    16, 0,  0,  16);
        run_phase(MODE_CPU,    4,  84, 0,  16);
        run_phase(MODE_DISK,   1,  0,  84, 16);
        run_phase(MODE_MEM,    7,  23, 23, 16);
        run_phase(MODE_CPU,    16, 0,  0,  16);
        run_phase(MODE_DISK,   16, 84, 0,  16);
        run_phase(MODE_UNUSED, 2,  0,  84, 16);
        run_phase(MODE_MEM,    $urandom_range(1, 16), 23, 23, 16);

        settle();
        if (expected_entries.size() != 0)
            log_mismatch($sformatf("%0d result words never arrived",
                                   expected_entries.size()));
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
